/* sv/scnt_pkg.sv */
// Package for the sorted circular neighbor table.
// Holds the table size, field widths, command and status codes and the
// result record shared by the sequencer and the top level. No dependencies.
package scnt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int HND_W       = 16;
    localparam int ENTRY_W     = KEY_W + HND_W;
    localparam int STATUS_W    = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HND_W-1:0]    prec_handle;
        logic [HND_W-1:0]    succ_handle;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_ctrl_stat;

endpackage

/* sv/sorted_circular_neighbor_table.sv */
// Top level of the sorted circular neighbor table: stream ports, output
// register, and the sequencer and entry RAM. Depends on scnt_pkg,
// scnt_ram and scnt_ctrl.
//
// The block keeps up to 64 entries, each a 32-bit binary-angle key with a
// 16-bit handle, sorted by ascending key in one RAM. An insert beat walks
// down from the end of the table, moving each entry with a key not smaller
// than the new one up by one place, and drops the new entry into the gap;
// it answers status full when the table already holds 64 entries. A find
// beat walks up from the first entry to the first key not smaller than the
// query and returns the handles before and at that place, wrapping to the
// last and first entries at either end, or status empty on an empty table.
// Every step of both walks is one RAM read and one compare through the
// single registered-read RAM port. An insert that walks down to the first
// entry ends with a separate write of the new entry there, and a find that
// stops at the first entry also reads the last entry for the wrap; a full
// insert, an empty find or an insert into an empty table visits no entry.
// The longest item is a find past all 64 entries. The input is ready only
// while the sequencer is idle; a finished result sits in the output
// register, so the next beat is taken while the previous result still
// waits downstream.
// There is no clearing pass: an entry is only read below the fill count.
module sorted_circular_neighbor_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // key [31:0], handle [47:32]
    input  logic        i_s_axis_tuser,   // cmd [0]: 0 insert, 1 find
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // prec_handle [15:0], succ_handle [31:16]
    output logic [1:0]  o_m_axis_tuser    // status [1:0]
);

    localparam int KW = scnt_pkg::KEY_W;
    localparam int HW = scnt_pkg::HND_W;

    scnt_pkg::t_ctrl_stat ctrl_stat;
    scnt_pkg::t_result    ctrl_result;
    logic                 in_beat;
    logic                 res_ready;

    logic                         wr_en, rd_en;
    logic [scnt_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
    logic [scnt_pkg::ENTRY_W-1:0] wr_data, rd_data;

    logic              r_out_valid;
    scnt_pkg::t_result r_out;

    // A new beat is taken whenever the sequencer is idle.
    assign o_s_axis_tready = ctrl_stat.idle;
    assign in_beat         = i_s_axis_tvalid & ctrl_stat.idle;

    // The output register can take a result when it is empty or being drained.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    scnt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_beat),
        .i_cmd       (i_s_axis_tuser),
        .i_key       (i_s_axis_tdata[KW-1:0]),
        .i_handle    (i_s_axis_tdata[KW+HW-1:KW]),
        .i_res_ready (res_ready),
        .o_stat      (ctrl_stat),
        .o_result    (ctrl_result),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    scnt_ram #(
        .WIDTH (scnt_pkg::ENTRY_W),
        .DEPTH (scnt_pkg::TABLE_DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Output register: loaded when the sequencer finishes and there is room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_stat.done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (ctrl_stat.done && res_ready) begin
            r_out <= ctrl_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.succ_handle, r_out.prec_handle};
    assign o_m_axis_tuser  = r_out.status;

endmodule

/* sv/scnt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the entry store of the neighbor table; no dependencies.
module scnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/scnt_ctrl.sv */
// Sequencer of the neighbor table: walks the entry RAM one entry at a time
// through a single key comparator. Depends on scnt_pkg and drives scnt_ram.
module scnt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_cmd,
    input  logic [scnt_pkg::KEY_W-1:0]    i_key,
    input  logic [scnt_pkg::HND_W-1:0]    i_handle,
    input  logic                          i_res_ready,
    output scnt_pkg::t_ctrl_stat          o_stat,
    output scnt_pkg::t_result             o_result,
    output logic                          o_wr_en,
    output logic [scnt_pkg::ADDR_W-1:0]   o_wr_addr,
    output logic [scnt_pkg::ENTRY_W-1:0]  o_wr_data,
    output logic                          o_rd_en,
    output logic [scnt_pkg::ADDR_W-1:0]   o_rd_addr,
    input  logic [scnt_pkg::ENTRY_W-1:0]  i_rd_data
);

    localparam int CW = scnt_pkg::CNT_W;
    localparam int AW = scnt_pkg::ADDR_W;
    localparam int KW = scnt_pkg::KEY_W;
    localparam int HW = scnt_pkg::HND_W;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INS_RD   = 9'b000000010,
        S_INS_CMP  = 9'b000000100,
        S_INS_PUT  = 9'b000001000,
        S_FND_RD   = 9'b000010000,
        S_FND_CMP  = 9'b000100000,
        S_FND_LRD  = 9'b001000000,
        S_FND_LAST = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    logic [KW-1:0]       r_key, n_key;
    logic [HW-1:0]       r_handle, n_handle;
    logic [HW-1:0]       r_prev, n_prev;
    logic [HW-1:0]       r_first, n_first;
    scnt_pkg::t_result   r_result, n_result;

    logic [CW-1:0]       idx_m1, idx_p1, cnt_m1;
    logic [KW-1:0]       rd_key;
    logic [HW-1:0]       rd_hnd;
    logic                key_lt;

    assign idx_m1 = r_idx - CW'(1);
    assign idx_p1 = r_idx + CW'(1);
    assign cnt_m1 = r_count - CW'(1);
    assign rd_key = i_rd_data[KW-1:0];
    assign rd_hnd = i_rd_data[scnt_pkg::ENTRY_W-1:KW];
    // The one shared comparator: is the stored key below the key in hand.
    assign key_lt = rd_key < r_key;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_key     = r_key;
        n_handle  = r_handle;
        n_prev    = r_prev;
        n_first   = r_first;
        n_result  = r_result;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx[AW-1:0];
        o_wr_data = {r_handle, r_key};
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_key                = i_key;
                    n_handle             = i_handle;
                    n_result.status      = scnt_pkg::ST_OK;
                    n_result.prec_handle = '0;
                    n_result.succ_handle = '0;
                    n_idx                = '0;
                    if (i_cmd == scnt_pkg::CMD_INSERT) begin
                        if (r_count == CW'(scnt_pkg::TABLE_DEPTH)) begin
                            n_result.status = scnt_pkg::ST_FULL;
                            n_state         = S_DONE;
                        end else if (r_count == '0) begin
                            o_wr_en   = 1'b1;
                            o_wr_addr = '0;
                            o_wr_data = {i_handle, i_key};
                            n_count   = r_count + CW'(1);
                            n_state   = S_DONE;
                        end else begin
                            n_idx   = r_count;
                            n_state = S_INS_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_result.status = scnt_pkg::ST_EMPTY;
                            n_state         = S_DONE;
                        end else begin
                            n_state = S_FND_RD;
                        end
                    end
                end
            end
            S_INS_RD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = idx_m1[AW-1:0];
                n_state   = S_INS_CMP;
            end
            S_INS_CMP: begin
                o_wr_en = 1'b1;
                if (key_lt) begin
                    // Entry below is smaller: the new entry goes into the gap.
                    n_count = r_count + CW'(1);
                    n_state = S_DONE;
                end else begin
                    o_wr_data = i_rd_data;
                    n_idx     = idx_m1;
                    n_state   = (idx_m1 == '0) ? S_INS_PUT : S_INS_RD;
                end
            end
            S_INS_PUT: begin
                o_wr_en = 1'b1;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_FND_RD: begin
                o_rd_en = 1'b1;
                n_state = S_FND_CMP;
            end
            S_FND_CMP: begin
                if (key_lt) begin
                    n_prev = rd_hnd;
                    if (r_idx == '0) begin
                        n_first = rd_hnd;
                    end
                    n_idx = idx_p1;
                    if (idx_p1 == r_count) begin
                        // Ran past the last entry: wrap to the first.
                        n_result.prec_handle = rd_hnd;
                        n_result.succ_handle = (r_idx == '0) ? rd_hnd : r_first;
                        n_state              = S_DONE;
                    end else begin
                        n_state = S_FND_RD;
                    end
                end else begin
                    n_result.succ_handle = rd_hnd;
                    if (r_idx == '0) begin
                        n_state = S_FND_LRD;
                    end else begin
                        n_result.prec_handle = r_prev;
                        n_state              = S_DONE;
                    end
                end
            end
            S_FND_LRD: begin
                o_rd_en   = 1'b1;
                o_rd_addr = cnt_m1[AW-1:0];
                n_state   = S_FND_LAST;
            end
            S_FND_LAST: begin
                n_result.prec_handle = rd_hnd;
                n_state              = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx    <= n_idx;
        r_key    <= n_key;
        r_handle <= n_handle;
        r_prev   <= n_prev;
        r_first  <= n_first;
        r_result <= n_result;
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.done = (r_state == S_DONE);
    assign o_result    = r_result;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(scnt_pkg::TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (CW'(o_wr_addr) <= r_count))
        else $error("write beyond the end of the filled table");

    a_rd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rd_en |-> (CW'(o_rd_addr) < r_count))
        else $error("read of an entry that holds no data");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_count != $past(r_count)))
            |-> (r_count == $past(r_count) + CW'(1)))
        else $error("entry count changed by other than one");

    a_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> ((r_state == S_DONE) || (r_state == S_IDLE)))
        else $error("left the result state other than to idle");
`endif

endmodule
